// ===== hw/rtl/sensor_matrix_creep_compensation_macros.svh =====
// Assertion macros for the creep compensation block.
`ifndef SENSOR_MATRIX_CREEP_COMPENSATION_MACROS_SVH
`define SENSOR_MATRIX_CREEP_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS
`define SMCC_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smcc assertion failed");
`define SMCC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smcc assertion failed");
`else
`define SMCC_ASSERT_IMPLIES(name, ante, cons)
`define SMCC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hw/rtl/smcc_pkg.sv =====
// Types and constants shared by the creep compensation block.
`default_nettype none

package smcc_pkg;

   localparam int SAMPLE_WIDTH = 8;
   localparam int INDEX_WIDTH  = 12;
   localparam int INDEX_SPAN   = 4096;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [SAMPLE_WIDTH-1:0] LOW_SAMPLE_LIMIT = 8'd2;
   localparam logic [SAMPLE_WIDTH-1:0] THRESHOLD_RESET  = 8'd1;
   localparam logic [SAMPLE_WIDTH-1:0] INTERVAL_RESET   = 8'd5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CREEP_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPDATE_INTERVAL = 2'd1;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic [INDEX_WIDTH-1:0]  cell_index;
      logic                    frame_start;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] display_value;
      logic [INDEX_WIDTH-1:0]  out_index;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] reference;
      logic [SAMPLE_WIDTH-1:0] offset;
   } cell_entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/smcc_cell_store.sv =====
// Per-cell reference and offset memory with a clearing sweep after reset.
`default_nettype none

module smcc_cell_store #(
   parameter int DEPTH      = 4096,
   parameter int ADDR_WIDTH = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           rd_en,
   input  wire logic [ADDR_WIDTH-1:0]          rd_addr,
   output      smcc_pkg::cell_entry_type       rd_data,
   input  wire logic                           wr_en,
   input  wire logic [ADDR_WIDTH-1:0]          wr_addr,
   input  wire smcc_pkg::cell_entry_type       wr_data,
   output      logic                           busy
);

   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(DEPTH - 1);

   smcc_pkg::cell_entry_type mem [DEPTH];
   smcc_pkg::cell_entry_type rd_data_ff;

   logic                  clearing_ff, clearing_in;
   logic [ADDR_WIDTH-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_WIDTH'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_matrix_creep_compensation.sv =====
// Top level of the pressure-matrix creep compensation block.
// Usage:
//   req channel: one beat per cell sample (sample, cell_index, frame_start).
//   rsp channel: one beat per request (display_value, out_index), in order.
//   csr channel: write creep_threshold (index 0) or update_interval
//     (index 1); csr_ready is always high. Write only while the block is idle.
// Results: an accepted request is registered in stage s1 and then in the
//   output register that drives rsp.
// Throughput: one beat per cycle unless a stall or the reset sweep holds it.
//   Cells are read when a request is accepted, written back as it leaves s1;
//   a write to the cell read at the same edge is forwarded to the following item.
// Reset: control state takes its reset values; a sweep zeroes the cell
//   memory, one entry per cycle, over min(CELL_COUNT, 4096) entries (4096 by
//   default); req_stall stays high then. CSR writes are taken throughout.
// Stall: when rsp_stall holds the output beat, one more request still
//   enters the pipeline stage behind it; after that req_stall rises until
//   the output beat is taken.
`default_nettype none

`include "sensor_matrix_creep_compensation_macros.svh"

module sensor_matrix_creep_compensation #(
   parameter int CELL_COUNT = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire smcc_pkg::req_type                     req_payload,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      smcc_pkg::rsp_type                     rsp_payload,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [smcc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [smcc_pkg::SAMPLE_WIDTH-1:0]     csr_data
);

   localparam int DEPTH = (CELL_COUNT < smcc_pkg::INDEX_SPAN) ? CELL_COUNT
                                                              : smcc_pkg::INDEX_SPAN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = smcc_pkg::SAMPLE_WIDTH;
   localparam int IW    = smcc_pkg::INDEX_WIDTH;

   logic [SW-1:0] threshold_ff, threshold_in;
   logic [SW-1:0] interval_ff, interval_in;
   logic [SW-1:0] phase_ff, phase_in;

   logic          s1_valid_ff, s1_valid_in;
   logic [SW-1:0] s1_sample_ff;
   logic [IW-1:0] s1_index_ff;
   logic          s1_update_ff;
   logic          s1_in_range_ff;
   logic          fwd_hit_ff;
   smcc_pkg::cell_entry_type fwd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   smcc_pkg::rsp_type rsp_payload_ff;

   logic          req_accept, s1_move, store_busy;
   logic          req_in_range, fwd_hit_in;
   logic [SW-1:0] phase_inc, item_phase;
   logic          phase_wrap;

   smcc_pkg::cell_entry_type rd_data, cur, wr_data;
   logic          wr_en;
   logic          is_low, is_up, absorb;
   logic [SW-1:0] dev, off_adj, disp;
   smcc_pkg::rsp_type rsp_next;

   smcc_cell_store #(
      .DEPTH      (DEPTH),
      .ADDR_WIDTH (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_payload.cell_index[AW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_index_ff[AW-1:0]),
      .wr_data (wr_data),
      .busy    (store_busy)
   );

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      interval_in  = interval_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            smcc_pkg::CSR_CREEP_THRESHOLD: threshold_in = csr_data;
            smcc_pkg::CSR_UPDATE_INTERVAL: interval_in  = csr_data;
            default: ;
         endcase
      end
   end

   // handshake
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = store_busy || (s1_valid_ff && !s1_move);
   assign req_accept = req_valid && !req_stall;

   // frame phase
   assign phase_inc  = phase_ff + SW'(1);
   assign phase_wrap = (interval_ff != '0) && (phase_inc >= interval_ff);
   assign item_phase = req_payload.frame_start ? (phase_wrap ? '0 : phase_inc) : phase_ff;
   assign phase_in   = req_accept ? item_phase : phase_ff;

   assign req_in_range = 32'(req_payload.cell_index) < 32'(CELL_COUNT);
   assign fwd_hit_in   = wr_en && (s1_index_ff == req_payload.cell_index);
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);

   // cell update
   always_comb begin
      cur     = fwd_hit_ff ? fwd_data_ff : rd_data;
      is_low  = s1_sample_ff < smcc_pkg::LOW_SAMPLE_LIMIT;
      is_up   = s1_sample_ff > cur.reference;
      dev     = is_up ? (s1_sample_ff - cur.reference) : (cur.reference - s1_sample_ff);
      absorb  = s1_update_ff && (dev <= threshold_ff);
      off_adj = cur.offset;
      if (absorb) begin
         off_adj = is_up ? (cur.offset + dev) : (cur.offset - dev);
      end
      wr_data.reference = s1_update_ff ? s1_sample_ff : cur.reference;
      wr_data.offset    = (s1_sample_ff < off_adj) ? '0 : off_adj;
      disp = (s1_sample_ff > off_adj) ? (s1_sample_ff - off_adj) : s1_sample_ff;
      if (is_low) begin
         wr_data.reference = cur.reference;
         wr_data.offset    = '0;
         disp              = '0;
      end
      if (!s1_in_range_ff) begin
         disp = '0;
      end
   end

   assign wr_en = s1_move && s1_in_range_ff;

   assign rsp_next.display_value = disp;
   assign rsp_next.out_index     = s1_index_ff;
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= smcc_pkg::THRESHOLD_RESET;
         interval_ff  <= smcc_pkg::INTERVAL_RESET;
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         interval_ff  <= interval_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff   <= req_payload.sample;
         s1_index_ff    <= req_payload.cell_index;
         s1_update_ff   <= (item_phase == '0);
         s1_in_range_ff <= req_in_range;
         fwd_hit_ff     <= fwd_hit_in;
         fwd_data_ff    <= wr_data;
      end
      if (s1_move) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `SMCC_ASSERT_IMPLIES(a_no_accept_in_sweep, store_busy, req_stall)
   `SMCC_ASSERT_NEXT(a_move_fills_output, s1_move, rsp_valid_ff)
   `SMCC_ASSERT_IMPLIES(a_fwd_after_write, fwd_hit_ff && $past(req_accept), $past(wr_en))
   `SMCC_ASSERT_IMPLIES(a_empty_output_drains, s1_valid_ff && !rsp_valid_ff, s1_move)

endmodule

`default_nettype wire

// ===== test/sensor_matrix_creep_compensation_tb.sv =====
// Self-checking testbench for the pressure-matrix creep compensation block.
module sensor_matrix_creep_compensation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW = smcc_pkg::SAMPLE_WIDTH;
   localparam int IW = smcc_pkg::INDEX_WIDTH;
   localparam int CW = smcc_pkg::CSR_INDEX_WIDTH;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   smcc_pkg::req_type          req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   smcc_pkg::rsp_type          rsp_payload;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CW-1:0]              csr_index = '0;
   logic [SW-1:0]              csr_data = '0;

   smcc_pkg::req_type cell_queue[$];
   smcc_pkg::rsp_type display_queue[$];

   logic [SW-1:0] level_mem [smcc_pkg::INDEX_SPAN];
   logic [SW-1:0] offset_mem [smcc_pkg::INDEX_SPAN];
   logic [SW-1:0] phase_model;
   logic [SW-1:0] creep_limit;
   logic [SW-1:0] update_every;

   logic [SW-1:0] scene_level [32];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;

   sensor_matrix_creep_compensation DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic smcc_pkg::rsp_type predict_display(input smcc_pkg::req_type beat);
      logic [SW-1:0] nxt;
      logic [SW-1:0] base_v;
      logic [SW-1:0] off_v;
      logic [SW-1:0] dev;
      logic [SW-1:0] smp;
      smcc_pkg::rsp_type result;
      smp = beat.sample;
      if (beat.frame_start) begin
         nxt = phase_model + 8'd1;
         if (update_every != 8'd0 && nxt >= update_every) nxt = 8'd0;
         phase_model = nxt;
      end
      base_v = level_mem[beat.cell_index];
      off_v = offset_mem[beat.cell_index];
      result.out_index = beat.cell_index;
      if (smp < smcc_pkg::LOW_SAMPLE_LIMIT) begin
         result.display_value = '0;
         off_v = '0;
      end else begin
         if (phase_model == 8'd0) begin
            dev = (smp > base_v) ? smp - base_v : base_v - smp;
            if (dev <= creep_limit) begin
               off_v = (smp > base_v) ? off_v + dev : off_v - dev;
            end
            base_v = smp;
         end
         result.display_value = (smp > off_v) ? smp - off_v : smp;
         if (smp < off_v) off_v = '0;
      end
      level_mem[beat.cell_index] = base_v;
      offset_mem[beat.cell_index] = off_v;
      return result;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            display_queue.push_back(predict_display(req_payload));
         end
         if (!(req_valid && req_stall)) begin
            if (cell_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= cell_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      smcc_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (display_queue.size() == 0) begin
               $error("result beat with no expectation waiting: display_value %0d out_index %0d",
                      rsp_payload.display_value, rsp_payload.out_index);
               mismatch_count++;
            end else begin
               want = display_queue.pop_front();
               if (rsp_payload.display_value !== want.display_value) begin
                  $error("display_value mismatch: expected %0d, got %0d",
                         want.display_value, rsp_payload.display_value);
                  mismatch_count++;
               end
               if (rsp_payload.out_index !== want.out_index) begin
                  $error("out_index mismatch: expected %0d, got %0d",
                         want.out_index, rsp_payload.out_index);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic push_cell(input logic [SW-1:0] smp,
                            input logic [IW-1:0] idx, input logic mark);
      smcc_pkg::req_type beat;
      beat.sample = smp;
      beat.cell_index = idx;
      beat.frame_start = mark;
      cell_queue.push_back(beat);
   endtask

   task automatic write_csr(input logic [CW-1:0] idx,
                            input logic [SW-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (idx == smcc_pkg::CSR_CREEP_THRESHOLD) creep_limit = value;
      else if (idx == smcc_pkg::CSR_UPDATE_INTERVAL) update_every = value;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (cell_queue.size() != 0 || req_valid || display_queue.size() != 0);
   endtask

   // mostly drifting frames over two small patches of cells, the rest noise
   task automatic queue_traffic(input int count);
      int produced;
      int span;
      int first;
      int slot;
      int roll;
      int drift;
      logic [SW-1:0] smp;
      produced = 0;
      while (produced < count) begin
         if ($urandom_range(99) < 80) begin
            span = $urandom_range(12, 4);
            first = $urandom_range(16 - span, 0) + ($urandom_range(1) ? 16 : 0);
            for (int k = 0; k < span; k++) begin
               slot = first + k;
               roll = $urandom_range(99);
               if (roll < 5) begin
                  smp = SW'($urandom_range(1));
               end else begin
                  if (roll < 12) begin
                     scene_level[slot] = SW'($urandom_range(255));
                  end else begin
                     drift = int'(scene_level[slot]) + int'($urandom_range(6)) - 3;
                     if (drift < 2) drift = 2;
                     if (drift > 255) drift = 255;
                     scene_level[slot] = drift[7:0];
                  end
                  smp = scene_level[slot];
               end
               push_cell(smp, IW'((slot < 16) ? slot : 4064 + slot), k == 0);
               produced++;
            end
         end else begin
            push_cell(SW'($urandom_range(255)), IW'($urandom_range(4095)),
                      $urandom_range(3) == 0);
            produced++;
         end
      end
   endtask

   task automatic run_phase(input logic [SW-1:0] thr,
                            input logic [SW-1:0] interval,
                            input int idle_pct, input int hold_pct, input int count);
      write_csr(smcc_pkg::CSR_CREEP_THRESHOLD, thr);
      write_csr(smcc_pkg::CSR_UPDATE_INTERVAL, interval);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = hold_pct;
      queue_traffic(count / 2);
      // hold the sender until every result of the first half is back
      wait_drained();
      queue_traffic(count - count / 2);
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < smcc_pkg::INDEX_SPAN; i++) begin
         level_mem[i] = '0;
         offset_mem[i] = '0;
      end
      for (int i = 0; i < 32; i++) scene_level[i] = SW'($urandom_range(255, 2));
      phase_model = '0;
      creep_limit = smcc_pkg::THRESHOLD_RESET;
      update_every = smcc_pkg::INTERVAL_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // cells before the first frame mark, low samples, creep both ways
      push_cell(8'd255, 12'd0, 1'b0);
      push_cell(8'd254, 12'd0, 1'b0);
      push_cell(8'd3, 12'd1, 1'b0);
      push_cell(8'd4, 12'd1, 1'b0);
      push_cell(8'd0, 12'd4095, 1'b0);
      push_cell(8'd1, 12'd4095, 1'b0);
      push_cell(8'd2, 12'd4095, 1'b0);
      push_cell(8'd3, 12'd4095, 1'b0);
      push_cell(8'd1, 12'd4095, 1'b0);
      push_cell(8'd4, 12'd1, 1'b1);
      push_cell(8'd170, 12'd2730, 1'b0);
      push_cell(8'd85, 12'd1365, 1'b1);
      push_cell(8'd128, 12'd2048, 1'b1);
      push_cell(8'd127, 12'd2047, 1'b1);
      push_cell(8'd5, 12'd1, 1'b1);
      push_cell(8'd3, 12'd1, 1'b0);
      push_cell(8'd2, 12'd1, 1'b0);
      push_cell(8'd1, 12'd1, 1'b0);
      push_cell(8'd255, 12'd0, 1'b1);
      push_cell(8'd255, 12'd0, 1'b1);
      push_cell(8'd255, 12'd0, 1'b1);
      wait_drained();

      // the first phase lowers the interval below the current frame phase
      run_phase(8'd255, 8'd2, 0, 0, 120);
      run_phase(8'd0, 8'd1, 58, 0, 120);
      run_phase(8'd8, 8'd255, 0, 58, 120);
      run_phase(8'd4, 8'd3, 36, 36, 150);
      run_phase(SW'($urandom_range(255)), SW'($urandom_range(8, 1)), 0, 0, 150);
      run_phase(smcc_pkg::THRESHOLD_RESET, smcc_pkg::INTERVAL_RESET, 58, 0, 120);
      run_phase(SW'($urandom_range(255)), SW'($urandom_range(255, 1)), 0, 58, 80);
      run_phase(8'd16, 8'd2, 36, 36, 80);

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
